// ===== rtl/sdgt_pkg.sv =====
// Shared types and constants for the sequence duplicate and gap tracker.
`default_nettype none

package sdgt_pkg;

  // Width of one sequence number.
  localparam int SeqW = 64;

  // Default number of recent numbers kept in the window.
  localparam int WindowDepthDefault = 256;

  // Number of cell hit flags combined in the first level of the match tree.
  localparam int HitGroupSize = 16;

  // Result event codes.
  typedef enum logic [1:0] {
    EV_IN_ORDER     = 2'd0,
    EV_DUPLICATE    = 2'd1,
    EV_OUT_OF_ORDER = 2'd2,
    EV_GAP          = 2'd3
  } event_t;

  // Sequencer states for one request.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_REDUCE_GROUPS,
    ST_REDUCE_ALL,
    ST_DECIDE
  } state_t;

  // Ordering of a new number against the highest number seen so far.
  typedef struct packed {
    logic            below;    // number is below the highest
    logic            above;    // number is above the highest
    logic            gap;      // number is more than one above the highest
    logic [SeqW-1:0] missing;  // count of skipped numbers, zero without a gap
  } order_t;

endpackage

`default_nettype wire

// ===== rtl/sequence_duplicate_gap_tracker.sv =====
// Top level of the sequence duplicate and gap tracker.
//
// Usage: each request on the s_ channel carries one 64-bit received sequence
// number. For each request one result leaves on the m_ channel with an event
// code (in order, duplicate, out of order, gap) and the count of skipped
// numbers for a gap. The last WINDOW_DEPTH non-duplicate numbers are kept in
// a row of cells that shifts by one on every new number; the oldest falls off.
// The result becomes valid once the request has passed the compare register
// in every cell, the first and second levels of the registered match tree and
// the decide state, which updates state. s_tready is high only while no
// request is in flight, so the block takes no new request before the last
// one has left its decide state.
// The output register holds one result. A new request is taken while that
// result waits; if the receiver stalls, the next request waits in its decide
// cycle until the output register is free.
// Reset (rst, synchronous) empties the window, clears the highest number and
// the output valid flag. No clearing pass is needed after reset.
`default_nettype none

module sequence_duplicate_gap_tracker
  import sdgt_pkg::*;
#(
  parameter int WINDOW_DEPTH = WindowDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [63:0] sequence_number
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata    // [1:0] event_code, [65:2] missing_count, zero pad
);

  localparam int NumGroups = (WINDOW_DEPTH + HitGroupSize - 1) / HitGroupSize;

  state_t          state;
  state_t          state_next;
  logic [SeqW-1:0] seq;
  logic            seen_any;
  logic [SeqW-1:0] highest;
  logic            advance;
  logic            shift_en;
  logic            out_free;
  logic            dup;
  event_t          out_code;
  logic [SeqW-1:0] out_missing;
  event_t          code_next;
  logic [SeqW-1:0] missing_next;
  order_t          order;

  logic [SeqW-1:0]                    cell_value [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]            cell_valid;
  logic [WINDOW_DEPTH-1:0]            cell_hit;
  logic [NumGroups*HitGroupSize-1:0]  hit_pad;
  logic [NumGroups-1:0]               group_hit;

  // Input register for the number under test.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      seq <= s_tdata;
    end
  end

  // Row of window cells; the new number enters at cell zero.
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      sdgt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift_en   (shift_en),
        .prev_value (seq),
        .prev_valid (1'b1),
        .query      (seq),
        .value      (cell_value[i]),
        .valid      (cell_valid[i]),
        .hit        (cell_hit[i])
      );
    end else begin : g_body
      sdgt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift_en   (shift_en),
        .prev_value (cell_value[i-1]),
        .prev_valid (cell_valid[i-1]),
        .query      (seq),
        .value      (cell_value[i]),
        .valid      (cell_valid[i]),
        .hit        (cell_hit[i])
      );
    end
  end

  // Match tree, first level: combine hits in groups.
  always_comb begin
    hit_pad = '0;
    hit_pad[WINDOW_DEPTH-1:0] = cell_hit;
  end

  for (genvar g = 0; g < NumGroups; g++) begin : g_group
    always_ff @(posedge clk) begin
      if (rst) begin
        group_hit[g] <= 1'b0;
      end else begin
        group_hit[g] <= |hit_pad[g*HitGroupSize +: HitGroupSize];
      end
    end
  end

  // Match tree, second level: any group hit means a duplicate.
  always_ff @(posedge clk) begin
    if (rst) begin
      dup <= 1'b0;
    end else begin
      dup <= |group_hit;
    end
  end

  // Ordering against the highest number seen.
  sdgt_order u_order (
    .clk     (clk),
    .seq     (seq),
    .highest (highest),
    .order   (order)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:          if (s_tvalid) state_next = ST_COMPARE;
      ST_COMPARE:       state_next = ST_REDUCE_GROUPS;
      ST_REDUCE_GROUPS: state_next = ST_REDUCE_ALL;
      ST_REDUCE_ALL:    state_next = ST_DECIDE;
      ST_DECIDE:        if (out_free) state_next = ST_IDLE;
      default:          state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    out_free = !m_tvalid || m_tready;
    s_tready = 1'b0;
    advance  = 1'b0;
    unique case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_DECIDE: advance  = out_free;
      default: begin
        s_tready = 1'b0;
        advance  = 1'b0;
      end
    endcase
    shift_en = advance && !dup;
  end

  // Classification of the number under test.
  always_comb begin
    code_next    = EV_IN_ORDER;
    missing_next = '0;
    if (dup) begin
      code_next = EV_DUPLICATE;
    end else if (seen_any) begin
      if (order.below) begin
        code_next = EV_OUT_OF_ORDER;
      end else if (order.gap) begin
        code_next    = EV_GAP;
        missing_next = order.missing;
      end
    end
  end

  // Highest number and first-number flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any <= 1'b0;
      highest  <= '0;
    end else if (shift_en) begin
      seen_any <= 1'b1;
      if (!seen_any || order.above) begin
        highest <= seq;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code    <= code_next;
      out_missing <= missing_next;
    end
  end

  assign m_tdata = {6'b0, out_missing, out_code};

`ifndef SYNTHESIS
  // A result other than a gap carries no skipped count.
  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_code != EV_GAP) |-> out_missing == '0)
    else $error("missing count set on a non-gap result");

  // A gap skips at least one number.
  a_gap_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_code == EV_GAP) |-> out_missing != '0)
    else $error("gap reported with zero missing count");

  // The highest number never falls once a number has been taken.
  a_highest_mono: assert property (@(posedge clk) disable iff (rst)
    seen_any && $past(seen_any) |-> highest >= $past(highest))
    else $error("highest number decreased");

  // The window only shifts when a result is produced.
  a_shift_with_result: assert property (@(posedge clk) disable iff (rst)
    shift_en |=> m_tvalid && seen_any)
    else $error("window shifted without a result");
`endif

endmodule

`default_nettype wire

// ===== rtl/sdgt_cell.sv =====
// One window cell: holds a recent sequence number and matches it against the query.
`default_nettype none

module sdgt_cell
  import sdgt_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift_en,
  input  wire logic [SeqW-1:0] prev_value,
  input  wire logic            prev_valid,
  input  wire logic [SeqW-1:0] query,
  output logic [SeqW-1:0]      value,
  output logic                 valid,
  output logic                 hit
);

  // The valid flag follows the window shift and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_en) begin
      valid <= prev_valid;
    end
  end

  // The stored number moves one cell on when a new number enters the window.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      value <= prev_value;
    end
  end

  // Local compare against the query, registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= valid && (value == query);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sdgt_order.sv =====
// Two-stage compare of a new number against the highest number seen.
`default_nettype none

module sdgt_order
  import sdgt_pkg::*;
(
  input  wire logic            clk,
  input  wire logic [SeqW-1:0] seq,
  input  wire logic [SeqW-1:0] highest,
  output order_t               order
);

  logic [SeqW:0] diff;

  // First stage: wide subtract, the top bit is the borrow.
  always_ff @(posedge clk) begin
    diff <= {1'b0, seq} - {1'b0, highest};
  end

  // Second stage: classify the difference and form the skipped count.
  always_ff @(posedge clk) begin
    order.below <= diff[SeqW];
    order.above <= !diff[SeqW] && (diff[SeqW-1:0] != '0);
    order.gap   <= !diff[SeqW] && (diff[SeqW-1:1] != '0);
    if (!diff[SeqW] && (diff[SeqW-1:1] != '0)) begin
      order.missing <= diff[SeqW-1:0] - {{(SeqW-1){1'b0}}, 1'b1};
    end else begin
      order.missing <= '0;
    end
  end

endmodule

`default_nettype wire

// ===== bench/sequence_duplicate_gap_tracker_test.sv =====
// Self-checking testbench for the sequence duplicate and gap tracker.
`timescale 1ns / 1ps

module sequence_duplicate_gap_tracker_test;
  import sdgt_pkg::*;

  localparam int Depth = WindowDepthDefault;
  localparam int IdleLimit = 3000;
  localparam int DrainCycles = 20;
  localparam int PressureCycles = 300;
  localparam int HistoryLimit = 1024;
  localparam logic [63:0] AllOnes = '1;

  // One classification as it leaves the block.
  typedef struct packed {
    event_t      code;
    logic [63:0] missing;
  } classification_t;

  // One directed request; pinned rows carry a hand-written outcome.
  typedef struct {
    logic [63:0]     number;
    bit              pinned;
    classification_t outcome;
  } stimulus_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // [63:0] sequence_number
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // [1:0] event_code, [65:2] missing_count, zero pad

  logic pressure_go = 1'b0;

  // Tracker state as the bench sees it.
  logic        tracked_seen = 1'b0;
  logic [63:0] tracked_highest = '0;
  logic [63:0] window_store [Depth];
  int          window_fill = 0;
  int          window_oldest = 0;

  classification_t awaited_classifications [$];
  logic [63:0]     number_history [$];

  int requests_taken = 0;
  int results_seen = 0;
  int error_count = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int code_tally [4] = '{0, 0, 0, 0};

  localparam classification_t NoPin = '{EV_IN_ORDER, 64'd0};

  // Opening requests: first number, duplicates, gaps and reordering at small values.
  stimulus_row_t opening_rows [14] = '{
    '{64'h0,  1'b1, '{EV_IN_ORDER,     64'd0}},
    '{64'h0,  1'b1, '{EV_DUPLICATE,    64'd0}},
    '{64'h1,  1'b1, '{EV_IN_ORDER,     64'd0}},
    '{64'h5,  1'b1, '{EV_GAP,          64'd3}},
    '{64'h3,  1'b1, '{EV_OUT_OF_ORDER, 64'd0}},
    '{64'h6,  1'b1, '{EV_IN_ORDER,     64'd0}},
    '{64'h6,  1'b1, '{EV_DUPLICATE,    64'd0}},
    '{64'h2,  1'b1, '{EV_OUT_OF_ORDER, 64'd0}},
    '{64'h2,  1'b1, '{EV_DUPLICATE,    64'd0}},
    '{64'h10, 1'b1, '{EV_GAP,          64'd9}},
    '{64'h0f, 1'b1, '{EV_OUT_OF_ORDER, 64'd0}},
    '{64'h11, 1'b1, '{EV_IN_ORDER,     64'd0}},
    '{64'h0,  1'b1, '{EV_DUPLICATE,    64'd0}},
    '{64'h20, 1'b1, '{EV_GAP,          64'd14}}
  };

  // Closing requests: the top of the number range, where no gap can follow.
  stimulus_row_t closing_rows [8] = '{
    '{AllOnes,                1'b0, NoPin},
    '{AllOnes,                1'b1, '{EV_DUPLICATE, 64'd0}},
    '{AllOnes - 64'd1,        1'b0, NoPin},
    '{64'h0,                  1'b0, NoPin},
    '{64'h8000_0000_0000_0000, 1'b0, NoPin},
    '{64'h7,                  1'b0, NoPin},
    '{64'h5555_5555_5555_5555, 1'b0, NoPin},
    '{AllOnes,                1'b1, '{EV_DUPLICATE, 64'd0}}
  };

  sequence_duplicate_gap_tracker uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Classify one number; for a non-duplicate, update the window, highest and eviction slot.
  function automatic classification_t classify_sequence(logic [63:0] number);
    classification_t outcome;
    outcome = NoPin;
    for (int i = 0; i < window_fill; i++) begin
      if (window_store[i] == number) begin
        outcome.code = EV_DUPLICATE;
        return outcome;
      end
    end
    if (tracked_seen) begin
      if (number < tracked_highest) begin
        outcome.code = EV_OUT_OF_ORDER;
      end else if (tracked_highest != AllOnes && number > tracked_highest + 64'd1) begin
        outcome.code = EV_GAP;
        outcome.missing = number - tracked_highest - 64'd1;
      end
    end
    if (!tracked_seen || number > tracked_highest) begin
      tracked_highest = number;
    end
    tracked_seen = 1'b1;
    // Fill the window first, then overwrite round robin.
    if (window_fill < Depth) begin
      window_store[window_fill] = number;
      window_fill++;
    end else begin
      window_store[window_oldest] = number;
      window_oldest = (window_oldest + 1) % Depth;
    end
    return outcome;
  endfunction

  // Mostly a plausible packet stream, with reorders, repeats, stale numbers and noise.
  function automatic logic [63:0] next_random_number();
    int choice;
    choice = $urandom_range(0, 99);
    if (choice < 45) return tracked_highest + 64'd1;
    if (choice < 60) return tracked_highest + 64'd2 + 64'($urandom_range(0, 40));
    if (choice < 72 && tracked_highest > 64'd40) begin
      return tracked_highest - 64'($urandom_range(1, 40));
    end
    if (choice < 85 && window_fill > 0) return window_store[$urandom_range(0, window_fill - 1)];
    if (choice < 92 && number_history.size() > 0) begin
      return number_history[$urandom_range(0, number_history.size() - 1)];
    end
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] wanted);
    $display("%0t ns: mismatch in %s: got %0h, wanted %0h", $time, what, got, wanted);
    error_count++;
  endtask

  // Offer one request and hold it until the block takes it.
  task automatic offer_number(logic [63:0] number, bit pinned, classification_t pinned_outcome);
    classification_t predicted;
    s_tvalid <= 1'b1;
    s_tdata <= number;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = classify_sequence(number);
    awaited_classifications.push_back(pinned ? pinned_outcome : predicted);
    number_history.push_back(number);
    if (number_history.size() > HistoryLimit) void'(number_history.pop_front());
    requests_taken++;
  endtask

  // Sender works in bursts; every third hundred requests runs without gaps.
  task automatic pace_sender();
    int pause;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 16);
    pause = ((requests_taken / 100) % 3 == 2) ? 0 : $urandom_range(1, 12);
    repeat (pause) begin
      s_tvalid <= 1'b0;
      s_tdata <= {$urandom, $urandom};
      @(posedge clk);
    end
  endtask

  // Receiver: one long hold-off on request, otherwise a rotating stall pattern.
  initial begin
    bit pressure_done;
    int cycle_count;
    int mode;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      if (pressure_go && !pressure_done) begin
        m_tready <= 1'b0;
        repeat (PressureCycles) @(posedge clk);
        pressure_done = 1'b1;
      end
      mode = (cycle_count / 64) % 4;
      case (mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= $urandom_range(0, 1);
        end
        2: begin
          m_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          m_tready <= ((cycle_count % 16) < 5);
        end
      endcase
      cycle_count++;
    end
  end

  // Compare each result with the oldest waiting classification.
  always @(posedge clk) begin
    classification_t wanted;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (awaited_classifications.size() == 0) begin
        report_mismatch("unexpected result, event code", 64'(m_tdata[1:0]), 64'd0);
      end else begin
        wanted = awaited_classifications.pop_front();
        code_tally[wanted.code]++;
        if (m_tdata[1:0] !== wanted.code) begin
          report_mismatch("event code", 64'(m_tdata[1:0]), 64'(wanted.code));
        end
        if (m_tdata[65:2] !== wanted.missing) begin
          report_mismatch("missing count", m_tdata[65:2], wanted.missing);
        end
        if (m_tdata[71:66] !== 6'd0) begin
          report_mismatch("padding", 64'(m_tdata[71:66]), 64'd0);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t ns: no handshake for %0d cycles", $time, IdleLimit);
      $display("sequence_duplicate_gap_tracker_test: done, errors");
      $finish;
    end
  end

  // Main stimulus.
  initial begin
    logic [63:0] eviction_peak;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_rows[i]) begin
      offer_number(opening_rows[i].number, opening_rows[i].pinned, opening_rows[i].outcome);
      pace_sender();
    end

    // Random stream; the receiver holds off early on so the block backs up.
    pressure_go <= 1'b1;
    repeat (200) begin
      offer_number(next_random_number(), 1'b0, NoPin);
      pace_sender();
    end

    // Push a new peak out of the window with older numbers, then repeat it.
    if (tracked_highest < 64'hFFFF_FFFF_FFFF_0000) begin
      offer_number(tracked_highest + 64'd1000, 1'b0, NoPin);
      pace_sender();
    end
    eviction_peak = tracked_highest;
    for (int k = 1; k <= Depth + 44; k++) begin
      offer_number(eviction_peak - 64'(k), 1'b0, NoPin);
      pace_sender();
    end
    offer_number(eviction_peak, 1'b0, NoPin);
    pace_sender();

    repeat (220) begin
      offer_number(next_random_number(), 1'b0, NoPin);
      pace_sender();
    end

    foreach (closing_rows[i]) begin
      offer_number(closing_rows[i].number, closing_rows[i].pinned, closing_rows[i].outcome);
      pace_sender();
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then allow a few more cycles for stray output.
    while (awaited_classifications.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d sequence numbers and checked %0d classifications: %0d in order,",
             requests_taken, results_seen, code_tally[EV_IN_ORDER]);
    $display("%0d duplicate, %0d out of order, %0d gap; window turnover and output stall done.",
             code_tally[EV_DUPLICATE], code_tally[EV_OUT_OF_ORDER], code_tally[EV_GAP]);
    if (error_count == 0) begin
      $display("sequence_duplicate_gap_tracker_test: done, clean");
    end else begin
      $display("sequence_duplicate_gap_tracker_test: done, errors");
    end
    $finish;
  end

endmodule
